/* hdl/keypress_ripple_renderer_defines.svh */
// ---------------------------------------------------------------------------
// Keypress ripple renderer: assertion macros
// Concurrent check macros; they compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef KEYPRESS_RIPPLE_RENDERER_DEFINES_SVH
`define KEYPRESS_RIPPLE_RENDERER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on aclk, off during reset
`define KPR_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kpr: same-cycle check failed");
// next-cycle implication, clocked on aclk, off during reset
`define KPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kpr: next-cycle check failed");
`else
`define KPR_ASSERT_IMPLY(lbl, ante, cons)
`define KPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/kpr_pkg.sv */
// ---------------------------------------------------------------------------
// kpr_pkg
// Shared constants and the fixed key layout map of the ripple renderer.
// ---------------------------------------------------------------------------
package kpr_pkg;

    localparam int KPR_RIPPLE_SLOTS = 10;
    localparam int KPR_NUM_KEYS     = 82;

    localparam int KPR_LIFE_MS   = 1000;
    localparam int KPR_RING_W    = 22;
    localparam int KPR_GROW_MUL  = 65;
    localparam int KPR_HUE_SPAN  = 43;
    localparam int KPR_RING_STEP = 255 / KPR_RING_W;
    // age / 6 as (age * 683) >> 12, exact for ages up to the ripple life
    localparam int KPR_DIV6_MUL  = 683;
    localparam int KPR_DIV6_SHR  = 12;

    localparam logic [7:0] KPR_BOTTOM_X [10] = '{
        8'd0, 8'd20, 8'd40, 8'd110, 8'd170, 8'd186, 8'd202, 8'd214, 8'd226, 8'd240
    };

    // x position of key / LED n; only the last row (n from 85) wraps to 8 bits
    function automatic logic [7:0] kpr_layout_x(input logic [6:0] n);
        logic [11:0] xv;
        logic [3:0]  bi;
        bi = 4'(n - 7'd72);
        if (n < 7'd14) begin
            xv = (12'd13 - 12'(n)) * 12'd17;
        end else if (n < 7'd29) begin
            xv = (12'(n) - 12'd14) * 12'd16;
        end else if (n < 7'd44) begin
            xv = 12'd6 + (12'd43 - 12'(n)) * 12'd16;
        end else if (n < 7'd58) begin
            xv = 12'd8 + (12'(n) - 12'd44) * 12'd17;
        end else if (n < 7'd72) begin
            xv = 12'd12 + (12'd71 - 12'(n)) * 12'd16;
        end else if (n < 7'd82) begin
            xv = 12'(KPR_BOTTOM_X[bi]);
        end else if (n < 7'd85) begin
            xv = 12'd232 + (12'(n) - 12'd82) * 12'd4;
        end else begin
            xv = (12'(n) - 12'd85) * 12'd13;
        end
        return xv[7:0];
    endfunction

    function automatic logic [6:0] kpr_layout_y(input logic [6:0] n);
        logic [6:0] yv;
        if (n < 7'd14) begin
            yv = 7'd0;
        end else if (n < 7'd29) begin
            yv = 7'd16;
        end else if (n < 7'd44) begin
            yv = 7'd32;
        end else if (n < 7'd58) begin
            yv = 7'd48;
        end else if (n < 7'd72) begin
            yv = 7'd64;
        end else if (n < 7'd85) begin
            yv = 7'd80;
        end else begin
            yv = 7'd96;
        end
        return yv;
    endfunction

endpackage

/* hdl/kpr_hsv.sv */
// ---------------------------------------------------------------------------
// kpr_hsv
// Two-stage 8-bit HSV to RGB conversion at full saturation.
// ---------------------------------------------------------------------------
module kpr_hsv import kpr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] hue,
    input  logic [7:0] val,
    output logic       out_valid,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    typedef enum logic [2:0] {
        SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
    } sector_t;

    sector_t     sec;
    logic [7:0]  sec_base;
    logic [7:0]  off;
    logic [10:0] rem_full;
    logic [7:0]  rem;
    logic [15:0] sq_full;
    logic [15:0] st_full;

    sector_t     sec_reg;
    logic [7:0]  qf_reg;
    logic [7:0]  tf_reg;
    logic [7:0]  v_reg;
    logic        a_valid_reg;

    logic [15:0] q_full;
    logic [15:0] t_full;
    logic [7:0]  q;
    logic [7:0]  t;

    // stage A: sector and fraction
    always_comb begin
        if (hue >= 8'(5 * KPR_HUE_SPAN)) begin
            sec = SEC_MR; sec_base = 8'(5 * KPR_HUE_SPAN);
        end else if (hue >= 8'(4 * KPR_HUE_SPAN)) begin
            sec = SEC_BM; sec_base = 8'(4 * KPR_HUE_SPAN);
        end else if (hue >= 8'(3 * KPR_HUE_SPAN)) begin
            sec = SEC_CB; sec_base = 8'(3 * KPR_HUE_SPAN);
        end else if (hue >= 8'(2 * KPR_HUE_SPAN)) begin
            sec = SEC_GC; sec_base = 8'(2 * KPR_HUE_SPAN);
        end else if (hue >= 8'(KPR_HUE_SPAN)) begin
            sec = SEC_YG; sec_base = 8'(KPR_HUE_SPAN);
        end else begin
            sec = SEC_RY; sec_base = 8'd0;
        end
        off      = hue - sec_base;
        rem_full = 11'(off) * 11'd6;
        rem      = rem_full[7:0];
        sq_full  = 16'(rem) * 16'd255;
        st_full  = 16'(8'd255 - rem) * 16'd255;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            out_valid   <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
            out_valid   <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            sec_reg <= sec;
            qf_reg  <= 8'd255 - sq_full[15:8];
            tf_reg  <= 8'd255 - st_full[15:8];
            v_reg   <= val;
        end
    end

    // stage B: scale by value; the p term is zero at full saturation
    always_comb begin
        q_full = 16'(v_reg) * 16'(qf_reg);
        t_full = 16'(v_reg) * 16'(tf_reg);
        q      = q_full[15:8];
        t      = t_full[15:8];
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg) begin
            case (sec_reg)
                SEC_RY: begin red <= v_reg; green <= t;     blue <= 8'd0;  end
                SEC_YG: begin red <= q;     green <= v_reg; blue <= 8'd0;  end
                SEC_GC: begin red <= 8'd0;  green <= v_reg; blue <= t;     end
                SEC_CB: begin red <= 8'd0;  green <= q;     blue <= v_reg; end
                SEC_BM: begin red <= t;     green <= 8'd0;  blue <= v_reg; end
                default: begin red <= v_reg; green <= 8'd0; blue <= q;     end
            endcase
        end
    end

endmodule

/* hdl/keypress_ripple_renderer.sv */
// ---------------------------------------------------------------------------
// keypress_ripple_renderer
// Key-press ripple lighting effect: key samples spawn ripples, render words
// return the color of one LED.
// ---------------------------------------------------------------------------
// Two kinds of input word share one channel. A key sample (func 0) compares
// the pressed bit with the key's previous state; on a press it stores a ripple
// (layout x,y and the start tick) in a ring of RIPPLE_SLOTS entries that
// overwrites its oldest slot. Keys at or above NUM_KEYS are ignored. A render
// word (func 1) returns one RGB word: the brightest live ripple at that LED,
// or black. A key sample holds the input through the S_KEY state (an ignored
// key skips it) for the read-modify-write of the key-state memory. A render
// word holds it through the walk over the stored ripples (none with an empty
// ring, at most RIPPLE_SLOTS), the color conversion and any wait for the
// output register to free up: the ripple memory is read one slot a cycle into
// a three-stage evaluation pipeline, then the two-stage HSV unit runs. A
// finished RGB word waits in the output register while the next input word is
// taken. Ripple and key-state storage need no clearing pass: slots are read
// only below the fill count, and key states carry a valid bit cleared by reset.
// ---------------------------------------------------------------------------
`include "keypress_ripple_renderer_defines.svh"

module keypress_ripple_renderer import kpr_pkg::*; #(
    parameter int RIPPLE_SLOTS = KPR_RIPPLE_SLOTS,
    parameter int NUM_KEYS     = KPR_NUM_KEYS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [6:0]  s_key_index,
    input  logic        s_pressed,
    input  logic [6:0]  s_pixel_index,
    input  logic [15:0] s_tick,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue
);

    localparam int SLOT_AW = (RIPPLE_SLOTS > 1) ? $clog2(RIPPLE_SLOTS) : 1;
    localparam int CNT_W   = $clog2(RIPPLE_SLOTS + 1);
    localparam int KEY_AW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [CNT_W-1:0]   SLOTS_C   = CNT_W'(RIPPLE_SLOTS);
    localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(RIPPLE_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_KEY, S_WALK, S_HSV, S_OUT
    } state_t;

    typedef struct packed {
        logic [7:0]  x;
        logic [6:0]  y;
        logic [15:0] start;
    } ripple_t;

    state_t state_reg;

    // latched input word
    logic [6:0]  key_reg;
    logic        pressed_reg;
    logic [15:0] tick_reg;
    logic [7:0]  px_reg;
    logic [6:0]  py_reg;

    logic accept;
    logic key_ok;

    // key-state memory with reset-cleared valid bits
    logic                kwd_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] kwd_vld_reg;
    logic                kwd_rd_reg;
    logic                was_down;
    logic                rise;

    // ripple ring memory
    ripple_t            rp_mem [RIPPLE_SLOTS];
    ripple_t            rp_rd_reg;
    ripple_t            rp_wdata;
    logic               rp_we;
    logic [SLOT_AW-1:0] wslot_reg;
    logic [SLOT_AW-1:0] wslot_next;
    logic [CNT_W-1:0]   live_cnt_reg;
    logic [CNT_W-1:0]   live_cnt_next;

    // walk over the ring
    logic [CNT_W-1:0] idx_reg;
    logic             issue;
    logic             walk_done;
    logic             p1_v_reg;
    logic             p2_v_reg;
    logic             p3_v_reg;

    // stage 1: age, radius, axis distances
    logic [15:0] age;
    logic [23:0] rad_full;
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic        p2_ok_reg;
    logic [9:0]  p2_age_reg;
    logic [7:0]  p2_rad_reg;
    logic [7:0]  p2_dx_reg;
    logic [7:0]  p2_dy_reg;
    logic [7:0]  p2_x_reg;
    logic [6:0]  p2_y_reg;

    // stage 2: distance, ring strength, fade, hue
    logic [9:0]  dx3;
    logic [9:0]  dy3;
    logic [8:0]  dist_full;
    logic [7:0]  oct_dist;
    logic [7:0]  delta;
    logic [15:0] ring_full;
    logic [19:0] div6_full;
    logic [8:0]  hue_full;
    logic        p3_hit_reg;
    logic [7:0]  p3_ring_reg;
    logic [7:0]  p3_fade_reg;
    logic [7:0]  p3_hue_reg;

    // stage 3: brightness and best pick
    logic [15:0] bright_full;
    logic [7:0]  bright;
    logic [7:0]  best_v_reg;
    logic [7:0]  best_h_reg;

    // color conversion and result register
    logic       hsv_ov;
    logic [7:0] hsv_r;
    logic [7:0] hsv_g;
    logic [7:0] hsv_b;
    logic       m_valid_reg;
    logic [7:0] m_red_reg;
    logic [7:0] m_green_reg;
    logic [7:0] m_blue_reg;
    logic       out_load;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign key_ok  = (s_key_index < 7'(NUM_KEYS));

    // ---- key sample: read previous state at accept, update next cycle ----
    assign was_down = kwd_vld_reg[key_reg[KEY_AW-1:0]] & kwd_rd_reg;
    assign rise     = pressed_reg & ~was_down;
    assign rp_we    = (state_reg == S_KEY) && rise;

    always_ff @(posedge aclk) begin
        if (accept && !s_func && key_ok) begin
            kwd_rd_reg <= kwd_mem[s_key_index[KEY_AW-1:0]];
        end
        if (state_reg == S_KEY) begin
            kwd_mem[key_reg[KEY_AW-1:0]] <= pressed_reg;
        end
    end

    // new ripple: layout position of the key plus its start tick
    assign rp_wdata.x     = kpr_layout_x(key_reg);
    assign rp_wdata.y     = kpr_layout_y(key_reg);
    assign rp_wdata.start = tick_reg;

    always_comb begin
        wslot_next    = (wslot_reg == LAST_SLOT) ? '0 : wslot_reg + 1'b1;
        live_cnt_next = (live_cnt_reg < SLOTS_C) ? live_cnt_reg + 1'b1 : live_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (rp_we) begin
            rp_mem[wslot_reg] <= rp_wdata;
        end
        if (issue) begin
            rp_rd_reg <= rp_mem[idx_reg[SLOT_AW-1:0]];
        end
    end

    // ---- walk: one slot read per cycle while below the fill count ----
    assign issue     = (state_reg == S_WALK) && (idx_reg < live_cnt_reg);
    assign walk_done = (state_reg == S_WALK) && !issue && !p1_v_reg && !p2_v_reg && !p3_v_reg;

    // stage 1
    always_comb begin
        age      = tick_reg - rp_rd_reg.start;
        rad_full = 24'(age) * 24'(KPR_GROW_MUL);
        rx       = rp_rd_reg.x;
        ry       = {1'b0, rp_rd_reg.y};
        dx       = (px_reg > rx) ? px_reg - rx : rx - px_reg;
        dy       = ({1'b0, py_reg} > ry) ? {1'b0, py_reg} - ry : ry - {1'b0, py_reg};
    end

    always_ff @(posedge aclk) begin
        if (p1_v_reg) begin
            p2_ok_reg  <= (age <= 16'(KPR_LIFE_MS));
            p2_age_reg <= age[9:0];
            p2_rad_reg <= rad_full[15:8];
            p2_dx_reg  <= dx;
            p2_dy_reg  <= dy;
            p2_x_reg   <= rp_rd_reg.x;
            p2_y_reg   <= rp_rd_reg.y;
        end
    end

    // stage 2: octagonal distance wraps to 8 bits
    always_comb begin
        dx3       = 10'(p2_dx_reg) * 10'd3;
        dy3       = 10'(p2_dy_reg) * 10'd3;
        dist_full = (p2_dx_reg > p2_dy_reg) ? 9'(p2_dx_reg) + 9'(dy3[9:3])
                                            : 9'(p2_dy_reg) + 9'(dx3[9:3]);
        oct_dist  = dist_full[7:0];
        delta     = (oct_dist > p2_rad_reg) ? oct_dist - p2_rad_reg : p2_rad_reg - oct_dist;
        ring_full = 16'(8'(KPR_RING_W) - delta) * 16'(KPR_RING_STEP);
        div6_full = 20'(p2_age_reg) * 20'(KPR_DIV6_MUL);
        hue_full  = 9'(p2_x_reg) + 9'({p2_y_reg, 1'b0})
                  + 9'(div6_full[19:KPR_DIV6_SHR]);
    end

    always_ff @(posedge aclk) begin
        if (p2_v_reg) begin
            p3_hit_reg  <= p2_ok_reg && (delta < 8'(KPR_RING_W));
            p3_ring_reg <= ring_full[7:0];
            p3_fade_reg <= ~p2_rad_reg;
            p3_hue_reg  <= hue_full[7:0];
        end
    end

    // stage 3: strictly brighter wins, so the lowest slot keeps a tie
    always_comb begin
        bright_full = 16'(p3_ring_reg) * 16'(p3_fade_reg);
        bright      = bright_full[15:8];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_func) begin
            best_v_reg <= 8'd0;
            best_h_reg <= 8'd0;
        end else if (p3_v_reg && p3_hit_reg && (bright > best_v_reg)) begin
            best_v_reg <= bright;
            best_h_reg <= p3_hue_reg;
        end
    end

    // ---- color conversion; zero value gives black ----
    kpr_hsv u_hsv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (walk_done),
        .hue       (best_h_reg),
        .val       (best_v_reg),
        .out_valid (hsv_ov),
        .red       (hsv_r),
        .green     (hsv_g),
        .blue      (hsv_b)
    );

    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // ---- item registers ----
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg     <= s_key_index;
            pressed_reg <= s_pressed;
            tick_reg    <= s_tick;
            px_reg      <= kpr_layout_x(s_pixel_index);
            py_reg      <= kpr_layout_y(s_pixel_index);
        end
        if (out_load) begin
            m_red_reg   <= hsv_r;
            m_green_reg <= hsv_g;
            m_blue_reg  <= hsv_b;
        end
    end

    // ---- control: state, ring pointer, fill count, pipeline valids ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            kwd_vld_reg  <= '0;
            wslot_reg    <= '0;
            live_cnt_reg <= '0;
            idx_reg      <= '0;
            p1_v_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            p3_v_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_v_reg <= issue;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            if (issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (rp_we) begin
                wslot_reg    <= wslot_next;
                live_cnt_reg <= live_cnt_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_func) begin
                            idx_reg   <= '0;
                            state_reg <= S_WALK;
                        end else if (key_ok) begin
                            state_reg <= S_KEY;
                        end
                    end
                end
                S_KEY: begin
                    kwd_vld_reg[key_reg[KEY_AW-1:0]] <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_WALK: begin
                    if (walk_done) begin
                        state_reg <= S_HSV;
                    end
                end
                S_HSV: begin
                    if (hsv_ov) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = m_red_reg;
    assign m_green = m_green_reg;
    assign m_blue  = m_blue_reg;

    // ---- checks ----
    `KPR_ASSERT_IMPLY(a_fill_bound, 1'b1, live_cnt_reg <= SLOTS_C)
    `KPR_ASSERT_IMPLY(a_slot_bound, 1'b1, CNT_W'(wslot_reg) < SLOTS_C)
    `KPR_ASSERT_NEXT(a_fill_grows, rp_we && (live_cnt_reg < SLOTS_C),
                     live_cnt_reg == $past(live_cnt_reg) + 1'b1)
    `KPR_ASSERT_IMPLY(a_hsv_in_state, hsv_ov, state_reg == S_HSV)
    `KPR_ASSERT_IMPLY(a_walk_in_range, issue, idx_reg < SLOTS_C)

endmodule
